>>> hdl/gcpi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpi_pkg: shared types and constants of the game clock
// Register indexes, the settings bundle, the clock state and the request item.
// ----------------------------------------------------------------------------
package gcpi_pkg;

  localparam int unsigned TimeW  = 31;
  localparam int unsigned STimeW = 32;
  localparam int unsigned MovesW = 10;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [TimeW-1:0]         ms_t;
  typedef logic signed [STimeW-1:0] sms_t;
  typedef logic [MovesW-1:0]        moves_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOVES_PER_PERIOD = 3'd0,
    CFG_PERIOD_TIME      = 3'd1,
    CFG_PER_MOVE_TIME    = 3'd2,
    CFG_INCREMENT        = 3'd3,
    CFG_EXPIRY_MARGIN    = 3'd4,
    CFG_INFINITE_TIME    = 3'd5
  } cfg_idx_t;

  // Request kinds
  typedef enum logic {
    MODE_START = 1'b0,
    MODE_MOVE  = 1'b1
  } mode_t;

  typedef struct packed {
    moves_t moves_per_period;
    ms_t    period_time_ms;
    ms_t    per_move_time_ms;
    ms_t    increment_ms;
    ms_t    expiry_margin_ms;
    logic   infinite_time;
  } cfg_t;

  typedef struct packed {
    sms_t   remaining_time;
    moves_t remaining_moves;
    logic   overrun_flag;
    ms_t    previous_move_time;
  } clk_state_t;

  typedef struct packed {
    mode_t mode;
    ms_t   elapsed_ms;
    logic  apply_increment;
  } item_t;

endpackage

>>> hdl/gcpi_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpi_cfg: settings register file
// Write-only registers loaded from the plain configuration write port.
// ----------------------------------------------------------------------------
module gcpi_cfg
  import gcpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata,
  output cfg_t               cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MOVES_PER_PERIOD: cfg_nxt.moves_per_period = cfg_wdata[MovesW-1:0];
        CFG_PERIOD_TIME:      cfg_nxt.period_time_ms   = cfg_wdata;
        CFG_PER_MOVE_TIME:    cfg_nxt.per_move_time_ms = cfg_wdata;
        CFG_INCREMENT:        cfg_nxt.increment_ms     = cfg_wdata;
        CFG_EXPIRY_MARGIN:    cfg_nxt.expiry_margin_ms = cfg_wdata;
        CFG_INFINITE_TIME:    cfg_nxt.infinite_time    = cfg_wdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/gcpi_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpi_step: clock update for one request
// Expiry check, time subtract/increment with saturation, period rollover.
// ----------------------------------------------------------------------------
module gcpi_step
  import gcpi_pkg::*;
(
  input  cfg_t       cfg,
  input  clk_state_t cur,
  input  item_t      item,
  output clk_state_t nxt
);

  localparam int unsigned WideW = STimeW + 2;

  // Clamp a 34-bit signed value to the signed 32-bit range
  function automatic sms_t sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(signed'({1'b0, {(STimeW-1){1'b1}}}));
    lo = -hi - WideW'(1);
    if (v > hi)      sat32 = {1'b0, {(STimeW-1){1'b1}}};
    else if (v < lo) sat32 = {1'b1, {(STimeW-1){1'b0}}};
    else             sat32 = v[STimeW-1:0];
  endfunction

  logic signed [STimeW:0]  limit;
  logic signed [STimeW:0]  elapsed_x;
  logic                    overrun;
  logic signed [WideW-1:0] inc_x;
  logic signed [WideW-1:0] diff;
  sms_t                    after_move;
  logic signed [WideW-1:0] with_period;
  sms_t                    after_period;
  logic                    per_move_on;
  logic                    period_on;

  // Arithmetic
  always_comb begin
    limit     = {cur.remaining_time[STimeW-1], cur.remaining_time}
              + {2'b00, cfg.expiry_margin_ms};
    elapsed_x = {2'b00, item.elapsed_ms};
    overrun   = !cfg.infinite_time && (elapsed_x > limit);
    inc_x     = item.apply_increment ? {3'b000, cfg.increment_ms} : '0;
    diff      = {{2{cur.remaining_time[STimeW-1]}}, cur.remaining_time}
              - {3'b000, item.elapsed_ms} + inc_x;
    after_move  = sat32(diff);
    with_period = {{2{after_move[STimeW-1]}}, after_move} + {3'b000, cfg.period_time_ms};
    after_period = sat32(with_period);
    per_move_on = (cfg.per_move_time_ms != '0);
    period_on   = (cfg.period_time_ms != '0);
  end

  // Next state
  always_comb begin
    nxt = cur;
    case (item.mode)
      MODE_START: begin
        nxt.overrun_flag       = 1'b0;
        nxt.previous_move_time = '0;
        if (period_on) begin
          nxt.remaining_time  = {1'b0, cfg.period_time_ms};
          nxt.remaining_moves = cfg.moves_per_period;
        end else if (per_move_on) begin
          nxt.remaining_time = {1'b0, cfg.per_move_time_ms};
        end
      end
      MODE_MOVE: begin
        nxt.previous_move_time = item.elapsed_ms;
        if (overrun) begin
          nxt.overrun_flag = 1'b1;
        end
        if (per_move_on) begin
          nxt.remaining_time = {1'b0, cfg.per_move_time_ms};
        end else begin
          nxt.remaining_time = after_move;
          if (cfg.moves_per_period != '0) begin
            // Period ends on its last move, or if the count already sits at zero
            if (cur.remaining_moves <= moves_t'(1)) begin
              nxt.remaining_moves = cfg.moves_per_period;
              nxt.remaining_time  = after_period;
            end else begin
              nxt.remaining_moves = cur.remaining_moves - moves_t'(1);
            end
          end
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

>>> hdl/game_clock_period_increment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// game_clock_period_increment: one player's game clock
// Start and move requests update remaining time, moves and the expired flag.
// ----------------------------------------------------------------------------
// Each request passes through an input register and the clock update
// logic, and its result is then held in the output register; a new request
// is accepted every cycle as long as the result side takes results, so
// throughput is one request per cycle; the input and result registers sit
// around the single update stage. The user must write settings through
// cfg_we/cfg_index/cfg_wdata only while no request is in flight; the block
// itself does not enforce this. Indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module game_clock_period_increment
  import gcpi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Settings write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimeW-1:0]   cfg_wdata,
  // Request channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // [30:0] elapsed_ms, [31] apply_increment
  input  logic [0:0]         in_tuser,   // [0] mode
  // Result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [79:0]        out_tdata   // [31:0] time_left_ms, [41:32] moves_left,
                                         // [42] expired, [73:43] last_move_ms, pad
);

  cfg_t       cfg;
  clk_state_t state_r;
  clk_state_t state_nxt;
  item_t      item_r;
  logic       item_vld_r;
  logic       res_vld_r;
  clk_state_t res_r;
  logic       advance;

  gcpi_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gcpi_step u_step (
    .cfg  (cfg),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt)
  );

  // Request moves on when the result register is free or being emptied
  assign advance   = item_vld_r && (!res_vld_r || out_tready);
  assign in_tready = !item_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.mode            <= mode_t'(in_tuser[0]);
      item_r.elapsed_ms      <= in_tdata[TimeW-1:0];
      item_r.apply_increment <= in_tdata[TimeW];
    end
  end

  // Clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_tready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= state_nxt;
    end
  end

  assign out_tvalid = res_vld_r;
  assign out_tdata  = {6'b0, res_r.previous_move_time, res_r.overrun_flag,
                       res_r.remaining_moves, res_r.remaining_time};

endmodule
